FILE: rtl/sd_spi_host_engine_core_defines.svh
// Assertion macros shared by the checker.
`ifndef SD_SPI_HOST_ENGINE_CORE_DEFINES_SVH
`define SD_SPI_HOST_ENGINE_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SDH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SDH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/sdh_pkg.sv
package sdh_pkg;
  // Input request codes.
  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_READ = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_RX = 3'd3;
  localparam logic [2:0] CMD_WBYTE = 3'd4;
  localparam logic [2:0] CMD_TICK = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_IDLE_RETRIES = 3'd0;
  localparam logic [2:0] REG_INIT_RETRIES = 3'd1;
  localparam logic [2:0] REG_CSD_POLLS = 3'd2;
  localparam logic [2:0] REG_READ_POLLS = 3'd3;
  localparam logic [2:0] REG_BUSY_POLLS = 3'd4;

  localparam int CFG_W = 24;
  localparam int BLOCK_BYTES = 512;
  localparam int CSD_BYTES = 16;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PWR, PH_SEND, PH_R1, PH_TICK, PH_R7, PH_OCR,
    PH_CSD_TOK, PH_CSD_DATA, PH_CSD_CRC, PH_TAIL,
    PH_RD_TOK, PH_RD_DATA, PH_RD_CRC,
    PH_WR_GAP, PH_WR_TOK, PH_WR_REQ, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY
  } phase_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] lba;
    logic [31:0] block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  tx_byte;
    logic        select_low;
    logic        fast_clock;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        want_write;
    logic        done_res;
    logic        ok;
    logic [1:0]  card_type;
    logic [31:0] sector_count;
    logic [20:0] megabytes;
  } res_t;

  // Command frame byte for a frame position.
  function automatic logic [7:0] frame_byte(input logic [2:0] f, input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] b;
    b = 8'hFF;
    case (f)
      3'd1: b = {2'b01, idx};
      3'd2: b = arg[31:24];
      3'd3: b = arg[23:16];
      3'd4: b = arg[15:8];
      3'd5: b = arg[7:0];
      default: begin
        if (idx == 6'd0) b = 8'h95;
        else if (idx == 6'd8) b = 8'h87;
      end
    endcase
    return b;
  endfunction
endpackage

FILE: rtl/sdh_if.sv
interface sdh_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sd_spi_host_engine_core.sv
// SD card SPI-mode host engine, one request per byte event. Every request is
// handled as it is accepted: the engine state is updated and at most one result
// is placed in an output register, so a request may follow each cycle while the
// result register is free or being taken. Result throughput is one per cycle,
// limited only by the output handshake; the SPI byte exchange outside sets the
// real pace.
module sd_spi_host_engine_core import sdh_pkg::*; #(
  parameter int R1_POLLS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  sdh_if.sink               in_ch,
  sdh_if.source             out_ch
);
  localparam int PW = $clog2(R1_POLLS + 1);

  logic [7:0]  idle_retries_r;
  logic [15:0] init_retries_r;
  logic [19:0] csd_polls_r, read_polls_r;
  logic [23:0] busy_polls_r;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  frame_r, frame_nxt;
  logic [5:0]  cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic [23:0] poll_r, poll_nxt;
  logic [15:0] retry_r, retry_nxt;
  logic [9:0]  bcnt_r, bcnt_nxt;
  logic [31:0] resp_r, resp_nxt;
  logic [127:0] csd_r, csd_nxt;
  logic        v2_r, v2_nxt, ready_r, ready_nxt, baddr_r, baddr_nxt, hc_r, hc_nxt;
  logic        sel_r, sel_nxt, fast_r, fast_nxt, opok_r, opok_nxt;
  logic [1:0]  kind_r, kind_nxt, type_r, type_nxt;
  logic [31:0] secs_r, secs_nxt, info_r, info_nxt, cur_r, cur_nxt, left_r, left_nxt;

  logic        ovalid_r;
  res_t        odata_r;
  logic        acc;
  req_t        rq;
  logic        any, snd, rv, want, done, okv;
  logic [7:0]  tx, rb;
  logic [31:0] csd_secs;
  logic [23:0] poll_inc;
  logic [23:0] tok_lim;

  sdh_csd_decode u_csd (.csd(csd_r), .sectors(csd_secs));

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign acc = in_ch.valid && in_ch.ready;
  assign rq = in_ch.data;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;
  assign poll_inc = poll_r + 24'd1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_retries_r <= 8'd10;
      init_retries_r <= 16'd2000;
      csd_polls_r <= 20'd50000;
      read_polls_r <= 20'd200000;
      busy_polls_r <= 24'd2000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_RETRIES: idle_retries_r <= cfg_data[7:0];
        REG_INIT_RETRIES: init_retries_r <= cfg_data[15:0];
        REG_CSD_POLLS: csd_polls_r <= cfg_data[19:0];
        REG_READ_POLLS: read_polls_r <= cfg_data[19:0];
        REG_BUSY_POLLS: busy_polls_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Engine next state for one request.
  always_comb begin
    phase_nxt = phase_r; frame_nxt = frame_r; cidx_nxt = cidx_r; carg_nxt = carg_r;
    poll_nxt = poll_r; retry_nxt = retry_r; bcnt_nxt = bcnt_r; resp_nxt = resp_r;
    csd_nxt = csd_r; v2_nxt = v2_r; ready_nxt = ready_r; baddr_nxt = baddr_r;
    hc_nxt = hc_r; sel_nxt = sel_r; fast_nxt = fast_r; opok_nxt = opok_r;
    kind_nxt = kind_r; type_nxt = type_r; secs_nxt = secs_r; info_nxt = info_r;
    cur_nxt = cur_r; left_nxt = left_r;
    any = 1'b0; snd = 1'b0; tx = 8'd0; rv = 1'b0; rb = 8'd0; want = 1'b0;
    done = 1'b0; okv = 1'b0;
    tok_lim = (phase_r == PH_CSD_TOK) ? 24'(csd_polls_r) : 24'(read_polls_r);
    if (tok_lim == 24'd0) tok_lim = 24'd1;

    case (rq.cmd)
      CMD_INIT: begin
        if (phase_r == PH_IDLE) begin
          kind_nxt = 2'd0; type_nxt = 2'd0; info_nxt = 32'd0; fast_nxt = 1'b0;
          sel_nxt = 1'b0; hc_nxt = 1'b0; v2_nxt = 1'b0;
          phase_nxt = PH_PWR; bcnt_nxt = 10'd0; snd = 1'b1; tx = 8'hFF;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (phase_r == PH_IDLE) begin
          if (!ready_r) begin
            done = 1'b1; any = 1'b1;
          end else begin
            kind_nxt = rq.cmd[1:0]; cur_nxt = rq.lba; left_nxt = rq.block_count;
            sel_nxt = 1'b1;
            if (rq.block_count == 32'd0) begin
              opok_nxt = 1'b1; sel_nxt = 1'b0; phase_nxt = PH_TAIL; snd = 1'b1; tx = 8'hFF;
            end else begin
              cidx_nxt = (rq.cmd == CMD_READ) ? 6'd17 : 6'd24;
              carg_nxt = baddr_r ? rq.lba : {rq.lba[22:0], 9'd0};
              frame_nxt = 3'd0; phase_nxt = PH_SEND; snd = 1'b1; tx = 8'hFF;
            end
          end
        end
      end
      CMD_WBYTE: begin
        if (phase_r == PH_WR_REQ) begin
          phase_nxt = PH_WR_DATA; snd = 1'b1; tx = rq.write_byte;
        end
      end
      CMD_TICK: begin
        if (phase_r == PH_TICK) begin
          if (cidx_r == 6'd0) begin
            if (retry_r >= ((idle_retries_r == 8'd0) ? 16'd1 : 16'(idle_retries_r))) begin
              opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
            end else begin
              cidx_nxt = 6'd0; carg_nxt = 32'd0; frame_nxt = 3'd0; phase_nxt = PH_SEND;
            end
          end else begin
            if (retry_r >= ((init_retries_r == 16'd0) ? 16'd1 : init_retries_r)) begin
              opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
            end else begin
              cidx_nxt = 6'd55; carg_nxt = 32'd0; frame_nxt = 3'd0; phase_nxt = PH_SEND;
            end
          end
          snd = 1'b1; tx = 8'hFF;
        end
      end
      CMD_RX: begin
        case (phase_r)
          PH_PWR: begin
            bcnt_nxt = bcnt_r + 10'd1; snd = 1'b1; tx = 8'hFF;
            if (bcnt_nxt >= 10'd10) begin
              sel_nxt = 1'b1; retry_nxt = 16'd0; cidx_nxt = 6'd0; carg_nxt = 32'd0;
              frame_nxt = 3'd0; phase_nxt = PH_SEND;
            end
          end
          PH_SEND: begin
            snd = 1'b1;
            if (frame_r < 3'd6) begin
              frame_nxt = frame_r + 3'd1; tx = frame_byte(frame_nxt, cidx_r, carg_r);
            end else begin
              phase_nxt = PH_R1; poll_nxt = 24'd0; tx = 8'hFF;
            end
          end
          PH_R1: begin
            poll_nxt = poll_inc;
            if (!rq.rx_byte[7] || poll_inc[PW-1:0] >= PW'(R1_POLLS) ||
                poll_inc[23:PW] != '0) begin
              snd = 1'b1; tx = 8'hFF; frame_nxt = 3'd0; phase_nxt = PH_SEND;
              case (cidx_r)
                6'd0: begin
                  if (rq.rx_byte == 8'h01) begin
                    cidx_nxt = 6'd8; carg_nxt = 32'h000001AA;
                  end else begin
                    retry_nxt = retry_r + 16'd1; phase_nxt = PH_TICK; snd = 1'b0; tx = 8'd0;
                  end
                end
                6'd8: begin
                  if (rq.rx_byte == 8'h01) begin
                    phase_nxt = PH_R7; bcnt_nxt = 10'd0; resp_nxt = 32'd0;
                  end else begin
                    v2_nxt = 1'b0; retry_nxt = 16'd0; cidx_nxt = 6'd55; carg_nxt = 32'd0;
                  end
                end
                6'd55: begin
                  cidx_nxt = 6'd41; carg_nxt = v2_r ? 32'h40000000 : 32'd0;
                end
                6'd41: begin
                  if (rq.rx_byte == 8'h00) begin
                    cidx_nxt = v2_r ? 6'd58 : 6'd16; carg_nxt = v2_r ? 32'd0 : 32'd512;
                  end else begin
                    retry_nxt = retry_r + 16'd1; phase_nxt = PH_TICK; snd = 1'b0; tx = 8'd0;
                  end
                end
                6'd58: begin
                  if (rq.rx_byte == 8'h00) begin
                    phase_nxt = PH_OCR; bcnt_nxt = 10'd0; resp_nxt = 32'd0;
                  end else begin
                    hc_nxt = 1'b0; cidx_nxt = 6'd9; carg_nxt = 32'd0;
                  end
                end
                6'd16: begin
                  cidx_nxt = 6'd9; carg_nxt = 32'd0;
                end
                6'd9: begin
                  if (rq.rx_byte == 8'h00) begin
                    phase_nxt = PH_CSD_TOK; poll_nxt = 24'd0;
                  end else begin
                    resp_nxt = 32'd0; opok_nxt = 1'b1; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
                  end
                end
                6'd17: begin
                  if (rq.rx_byte != 8'h00) begin
                    opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
                  end else begin
                    phase_nxt = PH_RD_TOK; poll_nxt = 24'd0;
                  end
                end
                6'd24: begin
                  if (rq.rx_byte != 8'h00) begin
                    opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
                  end else begin
                    phase_nxt = PH_WR_GAP;
                  end
                end
                default: begin
                  opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
                end
              endcase
            end else begin
              snd = 1'b1; tx = 8'hFF;
            end
          end
          PH_R7, PH_OCR: begin
            resp_nxt = {resp_r[23:0], rq.rx_byte}; bcnt_nxt = bcnt_r + 10'd1;
            snd = 1'b1; tx = 8'hFF;
            if (bcnt_nxt >= 10'd4) begin
              frame_nxt = 3'd0; phase_nxt = PH_SEND; carg_nxt = 32'd0;
              if (phase_r == PH_R7) begin
                v2_nxt = (resp_nxt[15:0] == 16'h01AA); retry_nxt = 16'd0; cidx_nxt = 6'd55;
              end else begin
                hc_nxt = resp_nxt[30]; cidx_nxt = 6'd9;
              end
            end
          end
          PH_CSD_TOK, PH_RD_TOK: begin
            poll_nxt = poll_inc; snd = 1'b1; tx = 8'hFF;
            if (rq.rx_byte == 8'hFE) begin
              bcnt_nxt = 10'd0;
              phase_nxt = (phase_r == PH_CSD_TOK) ? PH_CSD_DATA : PH_RD_DATA;
            end else if (rq.rx_byte != 8'hFF || poll_inc >= tok_lim) begin
              sel_nxt = 1'b0; phase_nxt = PH_TAIL;
              opok_nxt = (phase_r == PH_CSD_TOK);
              if (phase_r == PH_CSD_TOK) resp_nxt = 32'd0;
            end
          end
          PH_CSD_DATA: begin
            csd_nxt = {csd_r[119:0], rq.rx_byte};
            bcnt_nxt = bcnt_r + 10'd1; snd = 1'b1; tx = 8'hFF;
            if (bcnt_nxt >= 10'(CSD_BYTES)) begin
              phase_nxt = PH_CSD_CRC; bcnt_nxt = 10'd0;
            end
          end
          PH_CSD_CRC: begin
            bcnt_nxt = bcnt_r + 10'd1; snd = 1'b1; tx = 8'hFF;
            if (bcnt_nxt >= 10'd2) begin
              resp_nxt = csd_secs; opok_nxt = 1'b1; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
            end
          end
          PH_RD_DATA: begin
            rv = 1'b1; rb = rq.rx_byte; bcnt_nxt = bcnt_r + 10'd1; snd = 1'b1; tx = 8'hFF;
            if (bcnt_r == 10'(BLOCK_BYTES - 1)) begin
              phase_nxt = PH_RD_CRC; bcnt_nxt = 10'd0;
            end
          end
          PH_WR_GAP: begin
            phase_nxt = PH_WR_TOK; snd = 1'b1; tx = 8'hFE;
          end
          PH_WR_TOK: begin
            phase_nxt = PH_WR_REQ; bcnt_nxt = 10'd0; want = 1'b1;
          end
          PH_WR_DATA: begin
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_r != 10'(BLOCK_BYTES - 1)) begin
              phase_nxt = PH_WR_REQ; want = 1'b1;
            end else begin
              phase_nxt = PH_WR_CRC; bcnt_nxt = 10'd0; snd = 1'b1; tx = 8'hFF;
            end
          end
          PH_WR_CRC: begin
            bcnt_nxt = bcnt_r + 10'd1; snd = 1'b1; tx = 8'hFF;
            if (bcnt_nxt >= 10'd2) phase_nxt = PH_WR_RESP;
          end
          PH_WR_RESP: begin
            snd = 1'b1; tx = 8'hFF;
            if (rq.rx_byte[4:0] != 5'h05) begin
              opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
            end else begin
              phase_nxt = PH_WR_BUSY; poll_nxt = 24'd0;
            end
          end
          PH_WR_BUSY: begin
            poll_nxt = poll_inc; snd = 1'b1; tx = 8'hFF;
            if (rq.rx_byte != 8'hFF &&
                poll_inc >= ((busy_polls_r == 24'd0) ? 24'd1 : busy_polls_r)) begin
              opok_nxt = 1'b0; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
            end
          end
          PH_TAIL: begin
            if (kind_r == 2'd0 && opok_r) begin
              ready_nxt = 1'b1; baddr_nxt = v2_r && hc_r; secs_nxt = resp_r;
              type_nxt = v2_r ? (hc_r ? 2'd3 : 2'd2) : 2'd1;
              info_nxt = resp_r; fast_nxt = 1'b1;
            end
            phase_nxt = PH_IDLE; done = 1'b1; okv = opok_r;
          end
          default: ;
        endcase
        // Block completion after read CRC or busy release.
        if ((phase_r == PH_RD_CRC && bcnt_r == 10'd1) ||
            (phase_r == PH_WR_BUSY && rq.rx_byte == 8'hFF)) begin
          cur_nxt = cur_r + 32'd1; left_nxt = left_r - 32'd1; snd = 1'b1; tx = 8'hFF;
          if (left_nxt == 32'd0) begin
            opok_nxt = 1'b1; sel_nxt = 1'b0; phase_nxt = PH_TAIL;
          end else begin
            cidx_nxt = (kind_r == 2'd1) ? 6'd17 : 6'd24;
            carg_nxt = baddr_r ? cur_nxt : {cur_nxt[22:0], 9'd0};
            frame_nxt = 3'd0; phase_nxt = PH_SEND;
          end
        end else if (phase_r == PH_RD_CRC) begin
          bcnt_nxt = bcnt_r + 10'd1; snd = 1'b1; tx = 8'hFF;
        end
      end
      default: ;
    endcase
    any = any | snd | rv | want | done;
  end

  // Engine state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; frame_r <= 3'd0; cidx_r <= 6'd0; carg_r <= 32'd0;
      poll_r <= 24'd0; retry_r <= 16'd0; bcnt_r <= 10'd0; resp_r <= 32'd0;
      v2_r <= 1'b0; ready_r <= 1'b0; baddr_r <= 1'b0; hc_r <= 1'b0;
      sel_r <= 1'b0; fast_r <= 1'b0; opok_r <= 1'b0; kind_r <= 2'd0;
      type_r <= 2'd0; secs_r <= 32'd0; info_r <= 32'd0; cur_r <= 32'd0; left_r <= 32'd0;
    end else if (acc) begin
      phase_r <= phase_nxt; frame_r <= frame_nxt; cidx_r <= cidx_nxt; carg_r <= carg_nxt;
      poll_r <= poll_nxt; retry_r <= retry_nxt; bcnt_r <= bcnt_nxt; resp_r <= resp_nxt;
      v2_r <= v2_nxt; ready_r <= ready_nxt; baddr_r <= baddr_nxt; hc_r <= hc_nxt;
      sel_r <= sel_nxt; fast_r <= fast_nxt; opok_r <= opok_nxt; kind_r <= kind_nxt;
      type_r <= type_nxt; secs_r <= secs_nxt; info_r <= info_nxt; cur_r <= cur_nxt;
      left_r <= left_nxt;
    end
  end

  // CSD shift register holds payload only.
  always_ff @(posedge clk) begin
    if (acc) csd_r <= csd_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (in_ch.ready) begin
      ovalid_r <= acc && any;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && any) begin
      odata_r <= '{send_valid: snd, tx_byte: tx, select_low: sel_nxt, fast_clock: fast_nxt,
                   read_valid: rv, read_byte: rb, want_write: want, done_res: done,
                   ok: okv, card_type: type_nxt, sector_count: info_nxt,
                   megabytes: info_nxt[31:11]};
    end
  end
endmodule

FILE: rtl/sdh_csd_decode.sv
// Capacity decode from the stored CSD register, for CSD versions 1 and 2.
module sdh_csd_decode import sdh_pkg::*; (
  input  logic [127:0] csd,
  output logic [31:0]  sectors
);
  logic [7:0]  b0, b5, b6, b7, b8, b9, b10;
  logic [21:0] c2;
  logic [11:0] c1;
  logic [2:0]  m;
  logic [3:0]  bl;
  logic [5:0]  sh;
  logic [62:0] bytes;

  assign b0 = csd[127:120];
  assign b5 = csd[87:80];
  assign b6 = csd[79:72];
  assign b7 = csd[71:64];
  assign b8 = csd[63:56];
  assign b9 = csd[55:48];
  assign b10 = csd[47:40];

  always_comb begin
    c2 = {b7[5:0], b8, b9} + 22'd1;
    c1 = {b6[1:0], b7, b8[7:6]};
    m = {b9[1:0], b10[7]};
    bl = b5[3:0];
    sh = 6'(m) + 6'd2 + 6'(bl);
    bytes = 63'({1'b0, c1} + 13'd1) << sh;
    if (b0[7:6] == 2'b01) sectors = {c2[21:0], 10'd0};
    else sectors = bytes[40:9];
  end
endmodule

FILE: rtl/sdh_checker.sv
`include "sd_spi_host_engine_core_defines.svh"
// Port-level checks on the host engine.
module sdh_checker import sdh_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input res_t out_data
);
  `SDH_ASSERT_IMP(a_stall_hold, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while result stalled")
  `SDH_ASSERT_NXT(a_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `SDH_ASSERT_IMP(a_ok_done, clk, rst_n, out_valid && out_data.ok, out_data.done_res, "ok without done")
  `SDH_ASSERT_IMP(a_mb, clk, rst_n, out_valid, out_data.megabytes == out_data.sector_count[31:11], "capacity fields disagree")
endmodule

bind sd_spi_host_engine_core sdh_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

FILE: tb/sd_spi_host_engine_core_tb.sv
`timescale 1ns / 1ps

module sd_spi_host_engine_core_tb;
  import sdh_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int R1_TRIES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  sdh_if #(.T(req_t)) in_ch ();
  sdh_if #(.T(res_t)) out_ch ();

  sd_spi_host_engine_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Host engine state as the testbench model tracks it.
  logic [7:0] lim_idle;
  logic [15:0] lim_init;
  logic [19:0] lim_csd;
  logic [19:0] lim_read;
  logic [23:0] lim_busy;

  phase_t ph;
  logic [2:0] frm;
  logic [5:0] cmd_idx;
  logic [31:0] cmd_arg;
  logic [23:0] polls;
  logic [15:0] retries;
  logic [9:0] bytes_n;
  logic [31:0] resp_word;
  logic [7:0] csd_img [CSD_BYTES];
  logic is_v2, card_up, blk_mode;
  logic [31:0] sectors_kept, cur_blk, blks_left;
  logic sel_q, fast_q, hcs_q, op_good;
  logic [1:0] op_kind;
  logic [1:0] type_q;
  logic [31:0] sectors_q;

  res_t nxt;
  bit produced;

  res_t sector_q [$];
  int mismatches = 0;
  int active_items = 0;
  int cycle_cnt = 0;

  function automatic logic [31:0] at_least1(logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

  function automatic void emit(logic [7:0] b);
    nxt.send_valid = 1'b1;
    nxt.tx_byte = b;
    produced = 1'b1;
  endfunction

  function automatic logic [7:0] frame_out(logic [2:0] f);
    if (f == 3'd1) return {2'b01, cmd_idx};
    if (f >= 3'd2 && f <= 3'd5) return 8'(cmd_arg >> (8 * (5 - f)));
    if (cmd_idx == 6'd0) return 8'h95;
    if (cmd_idx == 6'd8) return 8'h87;
    return 8'hFF;
  endfunction

  function automatic void begin_cmd(logic [5:0] idx, logic [31:0] arg);
    cmd_idx = idx;
    cmd_arg = arg;
    frm = 0;
    ph = PH_SEND;
    emit(8'hFF);
  endfunction

  function automatic void close_op(logic good);
    op_good = good;
    sel_q = 1'b0;
    ph = PH_TAIL;
    emit(8'hFF);
  endfunction

  function automatic void init_win(logic [31:0] sec);
    resp_word = sec;
    close_op(1'b1);
  endfunction

  function automatic void next_blk();
    logic [31:0] addr;
    addr = blk_mode ? cur_blk : (cur_blk << 9);
    if (blks_left == 0) close_op(1'b1);
    else begin_cmd((op_kind == 2'd1) ? 6'd17 : 6'd24, addr);
  endfunction

  function automatic void blk_done();
    cur_blk = cur_blk + 1;
    blks_left = blks_left - 1;
    next_blk();
  endfunction

  // Capacity in sectors from the CSD, both structure versions.
  function automatic logic [31:0] csd_capacity();
    logic [31:0] c, bl, m;
    logic [63:0] nbytes;
    if (csd_img[0][7:6] == 2'b01) begin
      c = 32'({csd_img[7][5:0], csd_img[8], csd_img[9]});
      return (c + 1) * 32'd1024;
    end
    bl = 32'(csd_img[5][3:0]);
    c = 32'({csd_img[6][1:0], csd_img[7], csd_img[8][7:6]});
    m = 32'({csd_img[9][1:0], csd_img[10][7]});
    nbytes = 64'(c + 1) << (m + 2 + bl);
    return nbytes[40:9];
  endfunction

  function automatic void r1_done(logic [7:0] r1);
    case (cmd_idx)
      6'd0: begin
        if (r1 == 8'h01) begin_cmd(6'd8, 32'h000001AA);
        else begin
          retries = retries + 16'd1;
          ph = PH_TICK;
        end
      end
      6'd8: begin
        if (r1 == 8'h01) begin
          ph = PH_R7;
          bytes_n = 0;
          resp_word = 0;
          emit(8'hFF);
        end else begin
          is_v2 = 1'b0;
          retries = 0;
          begin_cmd(6'd55, 32'd0);
        end
      end
      6'd55: begin_cmd(6'd41, is_v2 ? 32'h40000000 : 32'd0);
      6'd41: begin
        if (r1 == 8'h00) begin
          if (is_v2) begin_cmd(6'd58, 32'd0);
          else begin_cmd(6'd16, 32'd512);
        end else begin
          retries = retries + 16'd1;
          ph = PH_TICK;
        end
      end
      6'd58: begin
        if (r1 == 8'h00) begin
          ph = PH_OCR;
          bytes_n = 0;
          resp_word = 0;
          emit(8'hFF);
        end else begin
          hcs_q = 1'b0;
          begin_cmd(6'd9, 32'd0);
        end
      end
      6'd16: begin_cmd(6'd9, 32'd0);
      6'd9: begin
        if (r1 == 8'h00) begin
          ph = PH_CSD_TOK;
          polls = 0;
          emit(8'hFF);
        end else init_win(32'd0);
      end
      6'd17: begin
        if (r1 != 8'h00) close_op(1'b0);
        else begin
          ph = PH_RD_TOK;
          polls = 0;
          emit(8'hFF);
        end
      end
      6'd24: begin
        if (r1 != 8'h00) close_op(1'b0);
        else begin
          ph = PH_WR_GAP;
          emit(8'hFF);
        end
      end
      default: close_op(1'b0);
    endcase
  endfunction

  // One byte answered by the card.
  function automatic void byte_in(logic [7:0] rx);
    logic [31:0] lim;
    case (ph)
      PH_PWR: begin
        bytes_n = bytes_n + 10'd1;
        if (bytes_n < 10) emit(8'hFF);
        else begin
          sel_q = 1'b1;
          retries = 0;
          begin_cmd(6'd0, 32'd0);
        end
      end
      PH_SEND: begin
        if (frm < 6) begin
          frm = frm + 3'd1;
          emit(frame_out(frm));
        end else begin
          ph = PH_R1;
          polls = 0;
          emit(8'hFF);
        end
      end
      PH_R1: begin
        polls = polls + 24'd1;
        if (!rx[7] || polls >= R1_TRIES) r1_done(rx);
        else emit(8'hFF);
      end
      PH_R7, PH_OCR: begin
        resp_word = {resp_word[23:0], rx};
        bytes_n = bytes_n + 10'd1;
        if (bytes_n < 4) emit(8'hFF);
        else if (ph == PH_R7) begin
          is_v2 = (resp_word[15:0] == 16'h01AA);
          retries = 0;
          begin_cmd(6'd55, 32'd0);
        end else begin
          hcs_q = resp_word[30];
          begin_cmd(6'd9, 32'd0);
        end
      end
      PH_CSD_TOK, PH_RD_TOK: begin
        polls = polls + 24'd1;
        lim = at_least1((ph == PH_CSD_TOK) ? 32'(lim_csd) : 32'(lim_read));
        if (rx != 8'hFF) begin
          if (rx == 8'hFE) begin
            bytes_n = 0;
            ph = (ph == PH_CSD_TOK) ? PH_CSD_DATA : PH_RD_DATA;
            emit(8'hFF);
          end else if (ph == PH_CSD_TOK) init_win(32'd0);
          else close_op(1'b0);
        end else if (32'(polls) >= lim) begin
          if (ph == PH_CSD_TOK) init_win(32'd0);
          else close_op(1'b0);
        end else emit(8'hFF);
      end
      PH_CSD_DATA: begin
        csd_img[bytes_n[3:0]] = rx;
        bytes_n = bytes_n + 10'd1;
        if (bytes_n >= CSD_BYTES) begin
          ph = PH_CSD_CRC;
          bytes_n = 0;
        end
        emit(8'hFF);
      end
      PH_CSD_CRC: begin
        bytes_n = bytes_n + 10'd1;
        if (bytes_n < 2) emit(8'hFF);
        else init_win(csd_capacity());
      end
      PH_RD_DATA: begin
        nxt.read_valid = 1'b1;
        nxt.read_byte = rx;
        bytes_n = bytes_n + 10'd1;
        if (bytes_n >= BLOCK_BYTES) begin
          ph = PH_RD_CRC;
          bytes_n = 0;
        end
        emit(8'hFF);
      end
      PH_RD_CRC: begin
        bytes_n = bytes_n + 10'd1;
        if (bytes_n < 2) emit(8'hFF);
        else blk_done();
      end
      PH_WR_GAP: begin
        ph = PH_WR_TOK;
        emit(8'hFE);
      end
      PH_WR_TOK: begin
        ph = PH_WR_REQ;
        bytes_n = 0;
        nxt.want_write = 1'b1;
        produced = 1'b1;
      end
      PH_WR_DATA: begin
        bytes_n = bytes_n + 10'd1;
        if (bytes_n < BLOCK_BYTES) begin
          ph = PH_WR_REQ;
          nxt.want_write = 1'b1;
          produced = 1'b1;
        end else begin
          ph = PH_WR_CRC;
          bytes_n = 0;
          emit(8'hFF);
        end
      end
      PH_WR_CRC: begin
        bytes_n = bytes_n + 10'd1;
        if (bytes_n < 2) emit(8'hFF);
        else begin
          ph = PH_WR_RESP;
          emit(8'hFF);
        end
      end
      PH_WR_RESP: begin
        if (rx[4:0] != 5'h05) close_op(1'b0);
        else begin
          ph = PH_WR_BUSY;
          polls = 0;
          emit(8'hFF);
        end
      end
      PH_WR_BUSY: begin
        polls = polls + 24'd1;
        if (rx == 8'hFF) blk_done();
        else if (32'(polls) >= at_least1(32'(lim_busy))) close_op(1'b0);
        else emit(8'hFF);
      end
      PH_TAIL: begin
        if (op_kind == 2'd0 && op_good) begin
          card_up = 1'b1;
          blk_mode = is_v2 && hcs_q;
          sectors_kept = resp_word;
          type_q = is_v2 ? (hcs_q ? 2'd3 : 2'd2) : 2'd1;
          sectors_q = resp_word;
          fast_q = 1'b1;
        end
        ph = PH_IDLE;
        nxt.done_res = 1'b1;
        nxt.ok = op_good;
        produced = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Next state and result of the engine for one accepted request.
  function automatic void engine_step(req_t r);
    produced = 1'b0;
    nxt = '0;
    case (r.cmd)
      CMD_INIT: begin
        if (ph == PH_IDLE) begin
          op_kind = 2'd0;
          type_q = 0;
          sectors_q = 0;
          fast_q = 1'b0;
          sel_q = 1'b0;
          hcs_q = 1'b0;
          is_v2 = 1'b0;
          ph = PH_PWR;
          bytes_n = 0;
          emit(8'hFF);
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (ph == PH_IDLE) begin
          if (!card_up) begin
            nxt.done_res = 1'b1;
            produced = 1'b1;
          end else begin
            op_kind = r.cmd[1:0];
            cur_blk = r.lba;
            blks_left = r.block_count;
            sel_q = 1'b1;
            next_blk();
          end
        end
      end
      CMD_RX: begin
        if (ph != PH_IDLE && ph != PH_TICK && ph != PH_WR_REQ) byte_in(r.rx_byte);
      end
      CMD_WBYTE: begin
        if (ph == PH_WR_REQ) begin
          ph = PH_WR_DATA;
          emit(r.write_byte);
        end
      end
      CMD_TICK: begin
        if (ph == PH_TICK) begin
          if (cmd_idx == 6'd0) begin
            if (32'(retries) >= at_least1(32'(lim_idle))) close_op(1'b0);
            else begin_cmd(6'd0, 32'd0);
          end else begin
            if (32'(retries) >= at_least1(32'(lim_init))) close_op(1'b0);
            else begin_cmd(6'd55, 32'd0);
          end
        end
      end
      default: ;
    endcase
    nxt.select_low = sel_q;
    nxt.fast_clock = fast_q;
    nxt.card_type = type_q;
    nxt.sector_count = sectors_q;
    nxt.megabytes = sectors_q[31:11];
  endfunction

  initial begin
    lim_idle = 8'd10;
    lim_init = 16'd2000;
    lim_csd = 20'd50000;
    lim_read = 20'd200000;
    lim_busy = 24'd2000000;
    ph = PH_IDLE;
    frm = 0;
    cmd_idx = 0;
    cmd_arg = 0;
    polls = 0;
    retries = 0;
    bytes_n = 0;
    resp_word = 0;
    is_v2 = 0;
    card_up = 0;
    blk_mode = 0;
    sectors_kept = 0;
    cur_blk = 0;
    blks_left = 0;
    sel_q = 0;
    fast_q = 0;
    hcs_q = 0;
    op_good = 0;
    op_kind = 0;
    type_q = 0;
    sectors_q = 0;
  end

  // Behavior of the emulated card for the current session.
  int card_c0_fail, card_a41_busy, card_rw_fail_at, card_noise;
  logic card_v2_echo, card_ocr_fail, card_csd_fail, card_wr_bad, card_busy_stuck;
  int card_csd_tok, card_rd_tok;
  logic [31:0] card_r7, card_ocr, card_start_cnt;
  logic [7:0] card_csd [CSD_BYTES];

  task automatic card_profile(bit clean);
    card_c0_fail = clean ? 0 : $urandom_range(0, 3);
    card_a41_busy = $urandom_range(0, 4);
    card_rw_fail_at = clean ? -1 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : -1);
    card_noise = clean ? 0 : $urandom_range(0, 6);
    card_v2_echo = clean ? 1'b1 : ($urandom_range(0, 3) != 0);
    card_r7 = ($urandom_range(0, 5) == 0) ? $urandom : {$urandom_range(0, 65535), 16'h01AA};
    if (clean) card_r7[15:0] = 16'h01AA;
    card_ocr = $urandom;
    card_ocr_fail = clean ? 1'b0 : ($urandom_range(0, 5) == 0);
    card_csd_fail = clean ? 1'b0 : ($urandom_range(0, 7) == 0);
    card_csd_tok = clean ? 0 : (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
    card_rd_tok = clean ? 0 : (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
    card_wr_bad = clean ? 1'b0 : ($urandom_range(0, 4) == 0);
    card_busy_stuck = clean ? 1'b0 : ($urandom_range(0, 4) == 0);
    foreach (card_csd[i]) card_csd[i] = 8'($urandom);
    card_csd[0][7:6] = 2'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      card_csd[7][5:0] = 6'h3F;
      card_csd[8] = 8'hFF;
      card_csd[9] = 8'hFF;
    end
  endtask

  function automatic logic [7:0] card_answer();
    logic [31:0] served;
    case (ph)
      PH_R1: begin
        if ($urandom_range(0, 4) == 0) return 8'hFF;
        case (cmd_idx)
          6'd0: begin
            if (card_c0_fail > 0) begin
              card_c0_fail--;
              return 8'h05;
            end
            return 8'h01;
          end
          6'd8: return card_v2_echo ? 8'h01 : 8'h05;
          6'd55: return 8'h01;
          6'd41: begin
            if (card_a41_busy > 0) begin
              card_a41_busy--;
              return 8'h01;
            end
            return 8'h00;
          end
          6'd58: return card_ocr_fail ? 8'h05 : 8'h00;
          6'd9: return card_csd_fail ? 8'h05 : 8'h00;
          6'd17, 6'd24: begin
            served = card_start_cnt - blks_left;
            return (card_rw_fail_at >= 0 && served == card_rw_fail_at) ? 8'h04 : 8'h00;
          end
          default: return 8'h00;
        endcase
      end
      PH_R7: return 8'(card_r7 >> (8 * (3 - bytes_n)));
      PH_OCR: return 8'(card_ocr >> (8 * (3 - bytes_n)));
      PH_CSD_TOK: begin
        if (card_csd_tok == 1) return 8'h0B;
        if (card_csd_tok == 2 && lim_csd <= 16) return 8'hFF;
        return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'hFE;
      end
      PH_CSD_DATA: return card_csd[bytes_n[3:0]];
      PH_RD_TOK: begin
        if (card_rd_tok == 1) return 8'h09;
        if (card_rd_tok == 2 && lim_read <= 16) return 8'hFF;
        return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'hFE;
      end
      PH_WR_RESP: return card_wr_bad ? 8'h0B : {3'($urandom), 5'h05};
      PH_WR_BUSY: begin
        if (card_busy_stuck && lim_busy <= 16) return 8'h00;
        return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // Sender: bursts of requests with random gaps.
  int burst_left = 0;

  task automatic send_req(req_t r);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    engine_step(r);
    if (produced) begin
      sector_q.push_back(nxt);
      active_items++;
    end
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic card_turn();
    req_t r;
    r.lba = $urandom;
    r.block_count = $urandom;
    r.rx_byte = 8'($urandom);
    r.write_byte = 8'($urandom);
    r.cmd = CMD_RX;
    if ($urandom_range(0, 99) < card_noise) r.cmd = 3'($urandom_range(0, 7));
    else if (ph == PH_TICK) r.cmd = CMD_TICK;
    else if (ph == PH_WR_REQ) r.cmd = CMD_WBYTE;
    else r.rx_byte = card_answer();
    send_req(r);
  endtask

  // Start one operation and play the card until the engine is idle again or the guard runs out.
  // The request line is dropped by the settle that follows.
  task automatic run_op(logic [2:0] op, logic [31:0] lba, logic [31:0] cnt);
    req_t r;
    int guard;
    r.cmd = op;
    r.lba = lba;
    r.block_count = cnt;
    r.rx_byte = 8'($urandom);
    r.write_byte = 8'($urandom);
    card_start_cnt = cnt;
    guard = 0;
    send_req(r);
    while (ph != PH_IDLE && guard < 40000) begin
      card_turn();
      guard++;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sector_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IDLE_RETRIES: lim_idle = val[7:0];
      REG_INIT_RETRIES: lim_init = val[15:0];
      REG_CSD_POLLS: lim_csd = val[19:0];
      REG_READ_POLLS: lim_read = val[19:0];
      REG_BUSY_POLLS: lim_busy = val[23:0];
      default: ;
    endcase
  endtask

  // Receiver: ready pattern that changes mode now and then.
  int stall_mode = 0;
  int stall_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 0);
        2: out_ch.ready <= (stall_cnt % 4 == 0);
        default: out_ch.ready <= ((stall_cnt / 8) % 2 == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_t exp_r, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (sector_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = sector_q.pop_front();
        if (got.send_valid !== exp_r.send_valid || got.tx_byte !== exp_r.tx_byte ||
            got.select_low !== exp_r.select_low || got.fast_clock !== exp_r.fast_clock ||
            got.read_valid !== exp_r.read_valid || got.read_byte !== exp_r.read_byte ||
            got.want_write !== exp_r.want_write || got.done_res !== exp_r.done_res ||
            got.ok !== exp_r.ok || got.card_type !== exp_r.card_type ||
            got.sector_count !== exp_r.sector_count ||
            got.megabytes !== exp_r.megabytes) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", exp_r, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Read and write before any init must fail at once.
  task automatic test_not_ready();
    card_profile(1'b1);
    run_op(CMD_READ, $urandom, 32'd1);
    run_op(CMD_WRITE, $urandom, 32'd3);
    settle();
  endtask

  // Clean v2 high-capacity init with a wrapping CSD v2 capacity.
  task automatic test_init_hc();
    card_profile(1'b1);
    card_ocr = 32'hC0FF8000;
    card_csd[0] = 8'h40;
    card_csd[7] = 8'h3F;
    card_csd[8] = 8'hFF;
    card_csd[9] = 8'hFF;
    run_op(CMD_INIT, '0, '0);
    settle();
  endtask

  // Zero-block transfers send only the closing byte.
  task automatic test_zero_blocks();
    card_profile(1'b1);
    run_op(CMD_READ, 32'hFFFFFFFF, 32'd0);
    run_op(CMD_WRITE, 32'd0, 32'd0);
    settle();
  endtask

  // Register extremes, zero limits and indexes out of range.
  task automatic test_limits();
    reg_write(REG_IDLE_RETRIES, 24'd1);
    card_profile(1'b0);
    card_c0_fail = 5;
    card_noise = 0;
    run_op(CMD_INIT, '0, '0);
    settle();
    reg_write(REG_IDLE_RETRIES, 24'hFFFFFF);
    reg_write(REG_INIT_RETRIES, 24'd0);
    card_profile(1'b1);
    card_a41_busy = 3;
    run_op(CMD_INIT, '0, '0);
    settle();
    reg_write(REG_INIT_RETRIES, 24'd65535);
    reg_write(REG_CSD_POLLS, 24'd0);
    card_profile(1'b1);
    card_csd_tok = 2;
    card_r7[15:0] = 16'h0000;
    run_op(CMD_INIT, '0, '0);
    settle();
    reg_write(REG_READ_POLLS, 24'd1);
    card_profile(1'b1);
    card_rd_tok = 2;
    run_op(CMD_READ, 32'hFFFFFFF0, 32'hFFFFFFFF);
    settle();
    reg_write(REG_BUSY_POLLS, 24'd0);
    reg_write(3'd5, 24'd0);
    reg_write(3'd7, 24'hFFFFFF);
    reg_write(REG_CSD_POLLS, 24'hFFFFF);
    reg_write(REG_READ_POLLS, 24'hFFFFF);
    settle();
  endtask

  task automatic random_limits();
    reg_write(REG_IDLE_RETRIES, $urandom_range(0, 3) == 0 ? 24'd1 : 24'($urandom_range(2, 20)));
    reg_write(REG_INIT_RETRIES, $urandom_range(0, 3) == 0 ? 24'd1 : 24'($urandom_range(2, 3000)));
    reg_write(REG_CSD_POLLS, $urandom_range(0, 2) == 0 ? 24'($urandom_range(0, 4)) : 24'd50000);
    reg_write(REG_READ_POLLS, $urandom_range(0, 2) == 0 ? 24'($urandom_range(0, 4)) : 24'hFFFFF);
    reg_write(REG_BUSY_POLLS, $urandom_range(0, 2) == 0 ? 24'($urandom_range(0, 4)) : 24'hFFFFFF);
    if ($urandom_range(0, 3) == 0) reg_write(3'($urandom_range(5, 7)), 24'($urandom));
  endtask

  // Random sessions: mostly well-formed inits and transfers with faults mixed in.
  task automatic test_random();
    int pick;
    bit did_rd, did_wr;
    logic [31:0] cnt;
    did_rd = 0;
    did_wr = 0;
    while (active_items < RANDOM_ITEMS || !did_rd || !did_wr) begin
      if ($urandom_range(0, 3) == 0) random_limits();
      card_profile($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 15);
      if (active_items > 600 && !did_rd) pick = 14;
      else if (active_items > 800 && !did_wr) pick = 15;
      if (pick < 8) begin
        run_op(CMD_INIT, $urandom, $urandom);
      end else if (pick < 14) begin
        cnt = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        card_rw_fail_at = 0;
        run_op($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, $urandom, cnt);
      end else begin
        if (!card_up) begin
          card_profile(1'b1);
          run_op(CMD_INIT, '0, '0);
          settle();
          card_profile(1'b0);
        end
        card_rw_fail_at = -1;
        card_busy_stuck = 1'b0;
        if (pick == 14) begin
          did_rd = 1;
          run_op(CMD_READ, $urandom, 32'd1);
        end else begin
          did_wr = 1;
          run_op(CMD_WRITE, $urandom, 32'd1);
        end
      end
      settle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_not_ready();
    test_init_hc();
    test_zero_blocks();
    test_limits();
    test_random();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && sector_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sdh_pkg.sv
rtl/sdh_if.sv
rtl/sdh_csd_decode.sv
rtl/sd_spi_host_engine_core.sv
rtl/sdh_checker.sv
tb/sd_spi_host_engine_core_tb.sv
